// ===== src/xsrng_pkg.sv =====
// shared types, constants and step functions for the xorshift128+ entropy generator
package xsrng_pkg;

    localparam int unsigned WORD_W = 64;
    localparam int unsigned HALF_W = WORD_W / 2;
    localparam int unsigned CMD_W  = 2;

    localparam logic [WORD_W-1:0] SEED_MIX_B       = 64'h0000_DEAD_BEEF_CAFE;
    localparam logic [WORD_W-1:0] SEED_MIX_ENTROPY = 64'h1234_5678_9ABC_DEF0;

    localparam int unsigned SHIFT_X_LEFT  = 23;
    localparam int unsigned SHIFT_X_RIGHT = 17;
    localparam int unsigned SHIFT_Y_RIGHT = 26;

    typedef enum logic [CMD_W-1:0] {
        CMD_SEED = 2'd0,
        CMD_ADD  = 2'd1,
        CMD_GET  = 2'd2
    } cmd_t;

    typedef struct packed {
        cmd_t              command;
        logic [WORD_W-1:0] tick_first;
        logic [WORD_W-1:0] tick_second;
        logic [WORD_W-1:0] tick_third;
    } item_t;

    typedef struct packed {
        logic [WORD_W-1:0] word_a;
        logic [WORD_W-1:0] word_b;
    } gen_state_t;

    typedef struct packed {
        logic              valid;
        logic [WORD_W-1:0] random_value;
        logic              late_seed_warning;
    } result_t;

    function automatic logic [WORD_W-1:0] swap_halves(input logic [WORD_W-1:0] v);
        return {v[HALF_W-1:0], v[WORD_W-1:HALF_W]};
    endfunction

    // xor the entropy word into word_a and its swapped halves into word_b
    function automatic gen_state_t mix(input gen_state_t s, input logic [WORD_W-1:0] v);
        gen_state_t r;
        r.word_a = s.word_a ^ v;
        r.word_b = s.word_b ^ swap_halves(v);
        return r;
    endfunction

    // one xorshift128+ state advance
    function automatic gen_state_t gen_step(input gen_state_t s);
        gen_state_t        r;
        logic [WORD_W-1:0] x;
        x        = s.word_a ^ (s.word_a << SHIFT_X_LEFT);
        r.word_a = s.word_b;
        r.word_b = x ^ s.word_b ^ (x >> SHIFT_X_RIGHT) ^ (s.word_b >> SHIFT_Y_RIGHT);
        return r;
    endfunction

endpackage

// ===== src/xsrng_in_reg.sv =====
// input holding register for one command word
module xsrng_in_reg
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  xsrng_pkg::item_t    in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output xsrng_pkg::item_t    out_item
);

    logic             valid_reg;
    logic             valid_next;
    xsrng_pkg::item_t item_reg;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= in_item;
        end
    end

endmodule

// ===== src/xsrng_step.sv =====
// combinational command decode, seeding, entropy mixing and generator steps
module xsrng_step
(
    input  xsrng_pkg::item_t       item,
    input  xsrng_pkg::gen_state_t  state,
    input  logic                   seeded,
    output xsrng_pkg::gen_state_t  state_next,
    output logic                   seeded_next,
    output xsrng_pkg::result_t     result
);

    xsrng_pkg::gen_state_t seed_base;
    xsrng_pkg::gen_state_t seed_mixed;
    xsrng_pkg::gen_state_t add_mixed;
    xsrng_pkg::gen_state_t pre;
    xsrng_pkg::gen_state_t step1;
    xsrng_pkg::gen_state_t step2;
    xsrng_pkg::gen_state_t step3;

    always_comb
    begin
        seed_base.word_a = item.tick_first;
        seed_base.word_b = item.tick_second ^ xsrng_pkg::SEED_MIX_B;
        seed_mixed = xsrng_pkg::mix(seed_base,
                                    item.tick_third ^ xsrng_pkg::SEED_MIX_ENTROPY);
        add_mixed  = xsrng_pkg::mix(state, item.tick_first);

        pre = state;
        unique case (item.command)
            xsrng_pkg::CMD_SEED: pre = seed_mixed;
            xsrng_pkg::CMD_ADD:  pre = add_mixed;
            xsrng_pkg::CMD_GET:  pre = seeded ? state : seed_mixed;
            default:             pre = state;
        endcase

        step1 = xsrng_pkg::gen_step(pre);
        step2 = xsrng_pkg::gen_step(step1);
        step3 = xsrng_pkg::gen_step(step2);

        state_next  = state;
        seeded_next = seeded;
        result.valid             = 1'b0;
        result.random_value      = step1.word_b + pre.word_b;
        result.late_seed_warning = !seeded;
        unique case (item.command)
            xsrng_pkg::CMD_SEED:
            begin
                // discarded steps only when already seeded before this word
                state_next  = seeded ? step3 : pre;
                seeded_next = 1'b1;
            end
            xsrng_pkg::CMD_ADD:
            begin
                state_next = seeded ? step3 : pre;
            end
            xsrng_pkg::CMD_GET:
            begin
                state_next   = step1;
                seeded_next  = 1'b1;
                result.valid = 1'b1;
            end
            default:
            begin
                state_next = state;
            end
        endcase
    end

endmodule

// ===== src/xorshift128p_entropy_rng_core.sv =====
// xorshift128+ generator with seeding and entropy commands, stream in and out
// a get word waits in the input register until its result is registered for m_tdata
// throughput: one command word per cycle while the result register can take a word,
// the update is combinational between the input and the state and result registers
// reset: both state words cleared, generator unseeded, no result pending
module xorshift128p_entropy_rng_core
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [191:0] s_tdata,   // tick_first[63:0], tick_second[127:64], tick_third[191:128]
    input  logic [1:0]   s_tuser,   // command[1:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [63:0]  m_tdata,   // random_value[63:0]
    output logic         m_tuser    // late_seed_warning[0]
);

    localparam int unsigned W = xsrng_pkg::WORD_W;

    xsrng_pkg::item_t      s_item;
    xsrng_pkg::item_t      cur_item;
    logic                  cur_valid;
    logic                  advance;
    logic                  out_free;

    xsrng_pkg::gen_state_t state_reg;
    xsrng_pkg::gen_state_t state_next;
    logic                  seeded_reg;
    logic                  seeded_next;
    xsrng_pkg::gen_state_t step_state;
    logic                  step_seeded;
    xsrng_pkg::result_t    step_result;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [W-1:0]          out_value_reg;
    logic                  out_warn_reg;

    always_comb
    begin
        s_item.command     = xsrng_pkg::cmd_t'(s_tuser);
        s_item.tick_first  = s_tdata[W-1:0];
        s_item.tick_second = s_tdata[2*W-1:W];
        s_item.tick_third  = s_tdata[3*W-1:2*W];
    end

    xsrng_in_reg u_in_reg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (s_item),
        .out_valid (cur_valid),
        .out_ready (advance),
        .out_item  (cur_item)
    );

    xsrng_step u_step
    (
        .item        (cur_item),
        .state       (state_reg),
        .seeded      (seeded_reg),
        .state_next  (step_state),
        .seeded_next (step_seeded),
        .result      (step_result)
    );

    // the held word moves on only when the result register can take a word
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = out_free;

    always_comb
    begin
        state_next     = state_reg;
        seeded_next    = seeded_reg;
        out_valid_next = out_valid_reg && !m_tready;
        if (cur_valid && advance)
        begin
            state_next  = step_state;
            seeded_next = step_seeded;
            if (step_result.valid)
            begin
                out_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            seeded_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            seeded_reg    <= seeded_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cur_valid && advance && step_result.valid)
        begin
            out_value_reg <= step_result.random_value;
            out_warn_reg  <= step_result.late_seed_warning;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_value_reg;
    assign m_tuser  = out_warn_reg;

endmodule
